// ===== sv/upd_pkg.sv =====
package upd_pkg;

   // Field widths
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned NibbleWidth = 4;

   // Special characters
   localparam logic [ByteWidth-1:0] ChPercent  = 8'h25;
   localparam logic [ByteWidth-1:0] ChPlus     = 8'h2B;
   localparam logic [ByteWidth-1:0] ChFragment = 8'h23;
   localparam logic [ByteWidth-1:0] ChSpace    = 8'h20;

   // Outcome of a string, reported with every result
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BADHEX     = 2'd1,
      ST_INCOMPLETE = 2'd2,
      ST_FRAGMENT   = 2'd3
   } status_type;

   // One input transaction
   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 last_byte;
   } req_item_type;

   // One result transaction
   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 out_valid;
      status_type           status;
      logic                 end_of_string;
   } rsp_item_type;

   // Hex digit value; bit 4 set means the byte is not a hex digit
   function automatic logic [NibbleWidth:0] hex_value(input logic [ByteWidth-1:0] c);
      logic [NibbleWidth:0] v;
      v = {1'b1, {NibbleWidth{1'b0}}};
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[NibbleWidth-1:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         // 'A'..'F' and 'a'..'f' share the low three bits: 1..6 -> 10..15
         v = {1'b0, 4'd9 + {1'b0, c[2:0]}};
      end
      return v;
   endfunction

endpackage

// ===== sv/upd_in_stage.sv =====
module upd_in_stage
   import upd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  req_item_type req_item,
   input  logic         take,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   // Free when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/upd_decode.sv =====
module upd_decode
   import upd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   input  logic         out_ready,
   output logic         take,
   output rsp_item_type result
);

   typedef enum logic [1:0] {
      PH_OUTSIDE = 2'd0,
      PH_HIGH    = 2'd1,
      PH_LOW     = 2'd2
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [NibbleWidth-1:0] nibble_ff, nibble_in;
   status_type             outcome_ff, outcome_in;
   logic [NibbleWidth:0]   hex;

   assign take = item_valid && out_ready;
   assign hex  = hex_value(item.data_byte);

   // Per-byte decode and next escape state
   always_comb begin
      phase_in   = phase_ff;
      nibble_in  = nibble_ff;
      outcome_in = outcome_ff;
      result     = '0;
      if (outcome_ff == ST_OK) begin
         unique case (phase_ff)
            PH_HIGH: begin
               if (hex[NibbleWidth]) begin
                  outcome_in = ST_BADHEX;
                  phase_in   = PH_OUTSIDE;
               end else begin
                  nibble_in = hex[NibbleWidth-1:0];
                  phase_in  = PH_LOW;
               end
            end
            PH_LOW: begin
               if (hex[NibbleWidth]) begin
                  outcome_in = ST_BADHEX;
               end else begin
                  result.out_byte  = {nibble_ff, hex[NibbleWidth-1:0]};
                  result.out_valid = 1'b1;
               end
               phase_in = PH_OUTSIDE;
            end
            default: begin
               // outside an escape, and the unused phase code
               phase_in = PH_OUTSIDE;
               priority if (item.data_byte == ChPercent) begin
                  phase_in  = PH_HIGH;
                  nibble_in = '0;
               end else if (item.data_byte == ChPlus) begin
                  result.out_byte  = ChSpace;
                  result.out_valid = 1'b1;
               end else if (item.data_byte == ChFragment) begin
                  outcome_in = ST_FRAGMENT;
               end else begin
                  result.out_byte  = item.data_byte;
                  result.out_valid = 1'b1;
               end
            end
         endcase
      end

      result.status        = outcome_in;
      result.end_of_string = item.last_byte;
      // End of string: final outcome, then clear for the next one
      if (item.last_byte) begin
         if (outcome_in == ST_OK && phase_in != PH_OUTSIDE) begin
            result.status = ST_INCOMPLETE;
         end
         phase_in   = PH_OUTSIDE;
         nibble_in  = '0;
         outcome_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OUTSIDE;
         nibble_ff  <= '0;
         outcome_ff <= ST_OK;
      end else if (take) begin
         phase_ff   <= phase_in;
         nibble_ff  <= nibble_in;
         outcome_ff <= outcome_in;
      end
   end

   // State is clear after the last byte of a string
   a_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      take && item.last_byte |=> phase_ff == PH_OUTSIDE && outcome_ff == ST_OK)
      else $error("escape state not cleared after end of string");

   // A sticky error or fragment mark drops every following byte
   a_drop_after_stop: assert property (@(posedge clock) disable iff (reset)
      item_valid && outcome_ff != ST_OK |-> !result.out_valid)
      else $error("byte emitted after decoding stopped");

   // A decoded byte always comes with a clean status
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      item_valid && result.out_valid |-> result.status == ST_OK)
      else $error("decoded byte with error status");

   // State only moves on a transaction
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(phase_ff) && $stable(outcome_ff) && $stable(nibble_ff))
      else $error("escape state changed without a transaction");

endmodule

// ===== sv/upd_out_stage.sv =====
module upd_out_stage
   import upd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         out_ready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_item_type rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   // Can take a new result when empty or when the held one leaves now
   assign out_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (out_ready) begin
         valid_in = load;
         item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

// ===== sv/url_percent_decoder_top.sv =====
// Streaming percent-decoder for URL text. One byte of the encoded string is
// taken per transaction on the req_ side, tlast marking the final byte; every
// input byte yields exactly one result transaction on the rsp_ side. The block
// accepts one byte per clock cycle while the receiver keeps rsp_tready high;
// an accepted byte is held in the input register, then passes through the
// decode logic into the result register, from which its result is presented.
// Backpressure on rsp_tready reaches req_tready in the same cycle. The result
// carries the decoded byte (zero and out_valid low when the byte produced
// nothing), the status so far (ok, bad hex digit, incomplete escape at end,
// stopped at fragment mark) and tlast, on which the status is the final
// outcome of the string; after that byte all decode state clears.
module url_percent_decoder_top
   import upd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [0] out_valid, [2:1] status
   output logic       rsp_tlast    // end_of_string
);

   req_item_type req_item, item;
   rsp_item_type result, rsp_item;
   logic         item_valid, take, out_ready;

   assign req_item.data_byte = req_tdata;
   assign req_item.last_byte = req_tlast;

   // Input register
   upd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // Decode logic and escape state
   upd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_ready  (out_ready),
      .take       (take),
      .result     (result)
   );

   // Result register
   upd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = rsp_item.out_byte;
   assign rsp_tuser = {rsp_item.status, rsp_item.out_valid};
   assign rsp_tlast = rsp_item.end_of_string;

endmodule

// ===== test/url_percent_decoder_top_tb.sv =====
module url_percent_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import upd_pkg::*;

   localparam int StuckLimit  = 2000;
   localparam int RandomBytes = 700;

   typedef enum logic [1:0] {
      PH_TEXT = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2
   } escape_phase_type;

   // Decode predictor plus the queue of results still owed by the block
   class decode_scoreboard;
      escape_phase_type phase;
      logic [3:0]       high_digit;
      status_type       sticky;
      rsp_item_type     pending_decodes[$];
      int               mismatches;
      int               unexpected;
      int               decoded_bytes;
      int               strings_done;
      int               outcomes[4];

      function new();
         phase         = PH_TEXT;
         high_digit    = '0;
         sticky        = ST_OK;
         mismatches    = 0;
         unexpected    = 0;
         decoded_bytes = 0;
         strings_done  = 0;
         foreach (outcomes[i]) outcomes[i] = 0;
      endfunction

      // Value of a hex digit; bit 4 set when c is not one
      function logic [4:0] digit_value(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
         if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
         if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
         return 5'h10;
      endfunction

      // Work out the result of one accepted input transaction
      function void predict_decode(logic [7:0] c, logic last);
         rsp_item_type exp_item;
         logic [4:0]   dv;
         exp_item = '0;
         dv       = digit_value(c);
         if (sticky == ST_OK) begin
            case (phase)
               PH_HIGH: begin
                  if (dv[4]) begin
                     sticky = ST_BADHEX;
                     phase  = PH_TEXT;
                  end else begin
                     high_digit = dv[3:0];
                     phase      = PH_LOW;
                  end
               end
               PH_LOW: begin
                  if (dv[4]) begin
                     sticky = ST_BADHEX;
                  end else begin
                     exp_item.out_byte  = {high_digit, dv[3:0]};
                     exp_item.out_valid = 1'b1;
                  end
                  phase = PH_TEXT;
               end
               default: begin
                  phase = PH_TEXT;
                  if (c == ChPercent) begin
                     phase      = PH_HIGH;
                     high_digit = '0;
                  end else if (c == ChPlus) begin
                     exp_item.out_byte  = ChSpace;
                     exp_item.out_valid = 1'b1;
                  end else if (c == ChFragment) begin
                     sticky = ST_FRAGMENT;
                  end else begin
                     exp_item.out_byte  = c;
                     exp_item.out_valid = 1'b1;
                  end
               end
            endcase
         end
         exp_item.status        = sticky;
         exp_item.end_of_string = last;
         // end of string: an open escape only counts if nothing else went wrong
         if (last) begin
            if (sticky == ST_OK && phase != PH_TEXT) exp_item.status = ST_INCOMPLETE;
            outcomes[exp_item.status]++;
            strings_done++;
            phase      = PH_TEXT;
            high_digit = '0;
            sticky     = ST_OK;
         end
         if (exp_item.out_valid) decoded_bytes++;
         pending_decodes = {pending_decodes, exp_item};
      endfunction

      // Compare one result transaction against the oldest expectation
      function void check_result(logic [7:0] tdata, logic [2:0] tuser, logic tlast);
         rsp_item_type exp_item;
         rsp_item_type got;
         got.out_byte      = tdata;
         got.out_valid     = tuser[0];
         got.status        = status_type'(tuser[2:1]);
         got.end_of_string = tlast;
         if (pending_decodes.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("%0t: unexpected result: out_byte %h out_valid %b status %0d tlast %b",
                        $realtime, got.out_byte, got.out_valid, got.status, got.end_of_string);
            return;
         end
         exp_item = pending_decodes.pop_front();
         if (got.out_byte !== exp_item.out_byte || got.out_valid !== exp_item.out_valid ||
             got.status !== exp_item.status ||
             got.end_of_string !== exp_item.end_of_string) begin
            mismatches++;
            if (mismatches + unexpected <= 10) begin
               $write("%0t: mismatch (exp/got): out_byte %h/%h out_valid %b/%b ", $realtime,
                      exp_item.out_byte, got.out_byte, exp_item.out_valid, got.out_valid);
               $display("status %0d/%0d tlast %b/%b", exp_item.status, got.status,
                        exp_item.end_of_string, got.end_of_string);
            end
         end
      endfunction

      function int pending();
         return pending_decodes.size();
      endfunction

      function int failures();
         return mismatches + unexpected + pending_decodes.size();
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   decode_scoreboard decode_sb;
   bit               no_idle     = 1'b0;
   int               bytes_sent  = 0;
   int               stall_left  = 0;
   int               stuck_count = 0;

   url_percent_decoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle length: mostly short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(20, 40);
   endfunction

   // Receiver backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
         stall_left = idle_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Sample both channels, feed the scoreboard, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) decode_sb.predict_decode(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) decode_sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stuck_count = 0;
         end else begin
            stuck_count++;
         end
         if (stuck_count >= StuckLimit) begin
            $display("%0t: no transaction for %0d cycles", $realtime, StuckLimit);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Drive one byte, with an optional gap in front, and wait for its transaction
   task automatic send_byte(input logic [7:0] c, input logic last);
      int gap;
      gap = (!no_idle && $urandom_range(0, 99) < 30) ? idle_len() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tlast  <= 1'($urandom);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] nibble_char(logic [3:0] n, bit upper);
      if (n < 4'd10) return 8'h30 + n;
      return (upper ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   // Any byte that is neither an escape nor a fragment mark
   function automatic logic [7:0] plain_byte(bit printable);
      logic [7:0] c;
      do c = printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
      while (c == ChPercent || c == ChFragment);
      return c;
   endfunction

   // Build one random string; mostly well-formed, otherwise with broken escapes,
   // fragment marks and a truncated tail
   task automatic send_random_string(input bit clean);
      logic [7:0] text[$];
      int         tokens;
      int         r;
      tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
      for (int t = 0; t < tokens; t++) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            text = {text, ChPercent};
            text = {text, nibble_char(4'($urandom), 1'($urandom))};
            text = {text, nibble_char(4'($urandom), 1'($urandom))};
         end else if (r < 50) begin
            text = {text, ChPlus};
         end else if (r < 80 || clean) begin
            text = {text, plain_byte(r < 90)};
         end else if (r < 86) begin
            text = {text, ChFragment};
         end else if (r < 94) begin
            // escape with an arbitrary digit in either position
            text = {text, ChPercent};
            if ($urandom_range(0, 1)) text = {text, nibble_char(4'($urandom), 1'($urandom))};
            text = {text, 8'($urandom_range(0, 255))};
         end else begin
            text = {text, 8'($urandom_range(0, 255))};
         end
      end
      // truncated escape at the end of the string
      if (!clean && $urandom_range(0, 3) == 0) begin
         text = {text, ChPercent};
         if ($urandom_range(0, 1)) text = {text, nibble_char(4'($urandom), 1'($urandom))};
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   initial begin
      int fails;
      int string_count;
      decode_sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: escape extremes in both cases, raw extremes, plus
      send_text("%00%fF");
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(ChPlus, 1'b1);
      // bad high digit as the last byte, after good output
      send_text("%9A%g");
      // fragment mark, later bytes dropped, open escape after it not reported
      send_text("#%x");
      // incomplete escape, ending in either digit phase
      send_text("ab%");
      send_text("%4");
      // fragment mark as the high digit, then a lone last byte
      send_text("%#z");
      send_text("/");

      // Random strings, with stretches where neither side idles
      string_count = 0;
      while (bytes_sent < RandomBytes + 25) begin
         no_idle = (string_count % 25) < 4;
         send_random_string($urandom_range(0, 99) < 75);
         string_count++;
      end
      no_idle = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (decode_sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      fails = decode_sb.failures();
      $display("Sent %0d bytes in %0d strings; %0d decoded bytes expected.",
               bytes_sent, decode_sb.strings_done, decode_sb.decoded_bytes);
      $display("String outcomes: ok %0d, bad hex %0d, incomplete %0d, fragment %0d.",
               decode_sb.outcomes[ST_OK], decode_sb.outcomes[ST_BADHEX],
               decode_sb.outcomes[ST_INCOMPLETE], decode_sb.outcomes[ST_FRAGMENT]);
      if (fails == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
